// ===== sv/markup_tag_balance_checker_top_macros.svh =====
// assertion shorthands for the checker module
`ifndef MARKUP_TAG_BALANCE_CHECKER_TOP_MACROS_SVH
`define MARKUP_TAG_BALANCE_CHECKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while reset is held
`define MTBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtbc check failed");

// next-cycle implication, sampled on clk, quiet while reset is held
`define MTBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtbc check failed");

`endif

// ===== sv/mtbc_pkg.sv =====
`timescale 1ns / 1ps
package mtbc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int NAME_LEN_DEF    = 16;

  // parser phases
  localparam logic [3:0] PH_TEXT    = 4'd0;
  localparam logic [3:0] PH_OPEN    = 4'd1;
  localparam logic [3:0] PH_BANG1   = 4'd2;
  localparam logic [3:0] PH_BANG2   = 4'd3;
  localparam logic [3:0] PH_SNAME   = 4'd4;
  localparam logic [3:0] PH_SATTR   = 4'd5;
  localparam logic [3:0] PH_SSLASH  = 4'd6;
  localparam logic [3:0] PH_ENAME   = 4'd7;
  localparam logic [3:0] PH_COMMENT = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // write strobes toward the name memories
  typedef struct packed {
    logic name_we;
    logic len_we;
  } mtbc_wr_t;

endpackage

// ===== sv/markup_tag_balance_checker_top.sv =====
// markup tag balance checker: one document byte per word, one result on the last byte
// throughput: one byte every cycle while no unread result stalls the input; the name memory read is prefetched
// result: the status word is registered and valid in the cycle after the last byte is accepted
// reset: rst_n synchronous active low; parser empty, no error, output register empty
// name memories are not cleared; rows above the stack top are never read for a result
`timescale 1ns / 1ps
module markup_tag_balance_checker_top #(
  parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DEF,
  parameter int NAME_LEN    = mtbc_pkg::NAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [5:0] out_open_depth
);
  import mtbc_pkg::*;

  localparam int TOP_W = $clog2(STACK_DEPTH + 1);
  localparam int ROW_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COL_W = $clog2(NAME_LEN);
  localparam int IDX_W = $clog2(NAME_LEN + 1);

  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(NAME_LEN);

  // parser state
  logic [3:0]       phase_r, phase_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       dash_r, dash_nxt;
  logic             cmp_ok_r, cmp_ok_nxt;
  logic [1:0]       err_r, err_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [5:0]       out_depth_r, out_depth_nxt;

  logic             acc;
  logic [7:0]       c;
  logic             start_byte;
  logic             put_req;
  logic             push_req;
  logic [1:0]       err_step;
  logic [TOP_W-1:0] top_step;
  mtbc_wr_t         wr;

  logic [TOP_W-1:0] rd_top_m1;
  logic [7:0]       rd_char;
  logic [IDX_W-1:0] rd_len;
  logic [TOP_W+5:0] depth_ext;

  // the output register frees the input side as soon as it is drained
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign c        = in_char_in;

  // bytes that continue a start tag name, including the prefix of a failed comment opener
  always_comb begin
    start_byte = 1'b0;
    unique case (phase_r)
      PH_OPEN:  start_byte = (c != CH_SLASH) && (c != CH_BANG);
      PH_BANG1: start_byte = (c != CH_DASH);
      PH_BANG2: start_byte = (c != CH_DASH);
      PH_SNAME: start_byte = 1'b1;
      default:  start_byte = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    top_step   = top_r;
    idx_nxt    = idx_r;
    dash_nxt   = dash_r;
    cmp_ok_nxt = cmp_ok_r;
    err_step   = err_r;
    put_req    = 1'b0;
    push_req   = 1'b0;
    wr         = '0;

    // a latched error freezes the parser until the last byte
    if (acc && (err_r == ST_OK)) begin
      if (start_byte) begin
        if (c == CH_GT) begin
          push_req  = 1'b1;
          phase_nxt = PH_TEXT;
        end else if (c == CH_SPACE) begin
          phase_nxt = PH_SATTR;
        end else if (c == CH_SLASH) begin
          phase_nxt = PH_SSLASH;
        end else begin
          put_req   = 1'b1;
          phase_nxt = PH_SNAME;
        end
      end else begin
        unique case (phase_r)
          PH_TEXT: begin
            if (c == CH_LT) begin
              phase_nxt  = PH_OPEN;
              idx_nxt    = '0;
              cmp_ok_nxt = 1'b1;
            end
          end
          PH_OPEN: begin
            if (c == CH_SLASH) begin
              phase_nxt = PH_ENAME;
            end else begin
              put_req   = 1'b1;
              phase_nxt = PH_BANG1;
            end
          end
          PH_BANG1: begin
            put_req   = 1'b1;
            phase_nxt = PH_BANG2;
          end
          PH_BANG2: begin
            phase_nxt = PH_COMMENT;
            dash_nxt  = 2'd2;
          end
          PH_SATTR: begin
            if (c == CH_GT) begin
              push_req  = 1'b1;
              phase_nxt = PH_TEXT;
            end else if (c == CH_SLASH) begin
              phase_nxt = PH_SSLASH;
            end
          end
          PH_SSLASH: begin
            if (c == CH_GT) begin
              phase_nxt = PH_TEXT;
            end
          end
          PH_ENAME: begin
            // rd_char and rd_len were fetched for the current top and index
            if (c == CH_GT) begin
              phase_nxt = PH_TEXT;
              if (top_r == '0) begin
                err_step = ST_MISMATCH;
              end else if (!cmp_ok_r || (idx_r != rd_len)) begin
                err_step = ST_MISMATCH;
              end else begin
                top_step = top_r - TOP_W'(1);
              end
            end else if (idx_r >= IDX_FULL) begin
              err_step = ST_TOO_LONG;
            end else begin
              if ((top_r == '0) || (rd_char != c)) begin
                cmp_ok_nxt = 1'b0;
              end
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          PH_COMMENT: begin
            if ((c == CH_GT) && (dash_r == 2'd2)) begin
              phase_nxt = PH_TEXT;
              dash_nxt  = 2'd0;
            end else if (c == CH_DASH) begin
              if (dash_r != 2'd2) begin
                dash_nxt = dash_r + 2'd1;
              end
            end else begin
              dash_nxt = 2'd0;
            end
          end
          default: begin
            phase_nxt = PH_TEXT;
          end
        endcase
      end

      // store one name character into the row above the top
      if (put_req) begin
        if (idx_r >= IDX_FULL) begin
          err_step = ST_TOO_LONG;
        end else begin
          wr.name_we = (top_r < TOP_FULL);
          idx_nxt    = idx_r + IDX_W'(1);
        end
      end

      // close a start tag: record its length and grow the stack
      if (push_req) begin
        if (top_r >= TOP_FULL) begin
          err_step = ST_OVERFLOW;
        end else begin
          wr.len_we = 1'b1;
          top_step  = top_r + TOP_W'(1);
        end
      end
    end

    top_nxt = top_step;
    err_nxt = err_step;
  end

  // result word and return to the empty document state on the last byte
  assign depth_ext = {6'd0, top_step};

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    if (acc && in_last_char) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = err_step;
      out_depth_nxt  = depth_ext[5:0];
    end
  end

  logic [3:0]       phase_fin;
  logic [TOP_W-1:0] top_fin;
  logic [IDX_W-1:0] idx_fin;
  logic [1:0]       dash_fin;
  logic             cmp_ok_fin;
  logic [1:0]       err_fin;

  always_comb begin
    phase_fin  = phase_nxt;
    top_fin    = top_nxt;
    idx_fin    = idx_nxt;
    dash_fin   = dash_nxt;
    cmp_ok_fin = cmp_ok_nxt;
    err_fin    = err_nxt;
    if (acc && in_last_char) begin
      phase_fin  = PH_TEXT;
      top_fin    = '0;
      idx_fin    = '0;
      dash_fin   = 2'd0;
      cmp_ok_fin = 1'b1;
      err_fin    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TEXT;
      top_r       <= '0;
      idx_r       <= '0;
      dash_r      <= 2'd0;
      cmp_ok_r    <= 1'b1;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_fin;
      top_r       <= top_fin;
      idx_r       <= idx_fin;
      dash_r      <= dash_fin;
      cmp_ok_r    <= cmp_ok_fin;
      err_r       <= err_fin;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  // prefetch the top entry for the state the next byte will see; an idle cycle
  // simply rereads the same place
  assign rd_top_m1 = top_fin - TOP_W'(1);

  mtbc_name_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .NAME_LEN    (NAME_LEN),
    .ROW_W       (ROW_W),
    .COL_W       (COL_W),
    .IDX_W       (IDX_W)
  ) u_name_mem (
    .clk     (clk),
    .wr      (wr),
    .wr_row  (top_r[ROW_W-1:0]),
    .wr_col  (idx_r[COL_W-1:0]),
    .wr_char (c),
    .wr_len  (idx_r),
    .rd_row  (rd_top_m1[ROW_W-1:0]),
    .rd_col  (idx_fin[COL_W-1:0]),
    .rd_char (rd_char),
    .rd_len  (rd_len)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_open_depth = out_depth_r;

endmodule

// ===== sv/mtbc_name_mem.sv =====
`timescale 1ns / 1ps
module mtbc_name_mem #(
  parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DEF,
  parameter int NAME_LEN    = mtbc_pkg::NAME_LEN_DEF,
  parameter int ROW_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int COL_W       = $clog2(NAME_LEN),
  parameter int IDX_W       = $clog2(NAME_LEN + 1)
) (
  input  logic               clk,
  input  mtbc_pkg::mtbc_wr_t wr,
  input  logic [ROW_W-1:0]   wr_row,
  input  logic [COL_W-1:0]   wr_col,
  input  logic [7:0]         wr_char,
  input  logic [IDX_W-1:0]   wr_len,
  input  logic [ROW_W-1:0]   rd_row,
  input  logic [COL_W-1:0]   rd_col,
  output logic [7:0]         rd_char,
  output logic [IDX_W-1:0]   rd_len
);
  import mtbc_pkg::*;

  localparam int NAME_WORDS = 2 ** (ROW_W + COL_W);
  localparam int LEN_WORDS  = 2 ** ROW_W;

  logic [7:0]       name_mem [NAME_WORDS];
  logic [IDX_W-1:0] len_mem  [LEN_WORDS];

  logic [7:0]       rd_char_r;
  logic [IDX_W-1:0] len_rd_r;
  logic [IDX_W-1:0] len_fwd_r;
  logic             len_fwd_sel_r;

  always_ff @(posedge clk) begin
    if (wr.name_we) begin
      name_mem[{wr_row, wr_col}] <= wr_char;
    end
    rd_char_r <= name_mem[{rd_row, rd_col}];
  end

  // a push writes the row that becomes the new top in the same cycle
  always_ff @(posedge clk) begin
    if (wr.len_we) begin
      len_mem[wr_row] <= wr_len;
    end
    len_rd_r      <= len_mem[rd_row];
    len_fwd_sel_r <= wr.len_we && (wr_row == rd_row);
    len_fwd_r     <= wr_len;
  end

  assign rd_char = rd_char_r;
  assign rd_len  = len_fwd_sel_r ? len_fwd_r : len_rd_r;

endmodule

// ===== sv/mtbc_checker.sv =====
`timescale 1ns / 1ps
`include "markup_tag_balance_checker_top_macros.svh"
module mtbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_open_depth
);

  // input side only backs up behind an unread result
  `MTBC_ASSERT_NOW(a_ready_only_blocked, !in_ready, out_valid && !out_ready)

  // the last byte always produces a result in the next cycle
  `MTBC_ASSERT_NEXT(a_last_gives_word, in_valid && in_ready && in_last_char, out_valid)

  // no result appears without a last byte
  `MTBC_ASSERT_NEXT(a_no_spurious_word,
    !out_valid && !(in_valid && in_ready && in_last_char), !out_valid)

  // a stalled result word holds
  `MTBC_ASSERT_NEXT(a_word_holds, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_open_depth))

endmodule

bind markup_tag_balance_checker_top mtbc_checker u_mtbc_checker (.*);
